### src/mpd_pkg.sv
// Shared types, codes and button tables for the mouse packet decoder.
package mpd_pkg;

  // Protocol register codes.
  localparam logic [1:0] ProtoFiveByte  = 2'd0;
  localparam logic [1:0] ProtoSevenBit  = 2'd1;
  localparam logic [1:0] ProtoPs2       = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgIdxProtocol = 2'd0;
  localparam logic [1:0] CfgIdxSwap     = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [1:0] ProtocolReset  = ProtoPs2;

  // Stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  typedef logic [2:0] btn_t;

  // Reverses the three button bits.
  localparam btn_t Rev3Map [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  // Five-byte format button map; the upper half is the shifted map.
  localparam btn_t FiveMap [16] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7,
                                    3'd0, 3'd2, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  // Seven-bit serial format button map, indexed by bits 5..4 of byte 0.
  localparam btn_t SevenMap [8] = '{3'd0, 3'd4, 3'd1, 3'd5, 3'd0, 3'd2, 3'd1, 3'd5};

  // PS/2 button map; the upper half applies while shift is held.
  localparam btn_t Ps2Map [16] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd7,
                                   3'd0, 3'd1, 3'd2, 3'd5, 3'd2, 3'd3, 3'd6, 3'd7};

  // One received byte with the keyboard shift state.
  typedef struct packed {
    logic       shift_held;
    logic [7:0] rx_byte;
  } item_t;

  // One report.
  typedef struct packed {
    logic signed [9:0] delta_y;
    logic signed [8:0] delta_x;
    btn_t              buttons;
  } report_t;

  // Configuration write.
  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [1:0] data;
  } cfg_wr_t;

endpackage

### src/mpd_in_reg.sv
// Input register that holds one received byte until the decoder takes it.
module mpd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  mpd_pkg::item_t  s_item_i,
  input  logic            consume_i,
  output logic            item_valid_o,
  output mpd_pkg::item_t  item_o
);

  logic           valid_q, valid_d;
  mpd_pkg::item_t item_q;

  // A slot is free when empty or when its item leaves in this cycle.
  assign s_ready_o = !valid_q || consume_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### src/mpd_decode.sv
// Packet assembly state, configuration registers and report decoding.
module mpd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpd_pkg::cfg_wr_t  cfg_i,
  input  logic              item_valid_i,
  input  mpd_pkg::item_t    item_i,
  input  logic              out_ready_i,
  output logic              consume_o,
  output logic              emit_o,
  output mpd_pkg::report_t  report_o
);

  logic [1:0] protocol_q;
  logic       swap_q;
  logic [2:0] byte_index_q, byte_index_d;
  logic [7:0] pkt_q [4];
  logic       middle_held_q, middle_held_d;
  mpd_pkg::btn_t last_buttons_q;

  logic       fire;
  logic [2:0] idx;
  logic       store_en;
  logic [7:0] store_val;
  logic       emit;
  mpd_pkg::btn_t btn_raw, btn_final;
  logic [8:0] dx;
  logic [9:0] dy;
  logic [7:0] c;
  logic [9:0] sum_y;
  logic [8:0] ps2_y;
  logic [7:0] seven_x, seven_y;

  assign c         = item_i.rx_byte;
  assign fire      = item_valid_i && out_ready_i;
  assign consume_o = fire;

  // Per-format decode of the current byte against the stored packet.
  always_comb begin
    idx           = byte_index_q;
    byte_index_d  = byte_index_q;
    middle_held_d = middle_held_q;
    store_en      = 1'b0;
    store_val     = c;
    emit          = 1'b0;
    btn_raw       = '0;
    dx            = '0;
    dy            = '0;
    sum_y         = {{2{pkt_q[2][7]}}, pkt_q[2]} + {{2{c[7]}}, c};
    ps2_y         = {pkt_q[0][5], c};
    seven_x       = {pkt_q[0][1:0], pkt_q[1][5:0]};
    seven_y       = {pkt_q[0][3:2], c[5:0]};
    case (protocol_q)
      mpd_pkg::ProtoFiveByte: begin
        if (c[7:4] == 4'h8 || byte_index_q > 3'd4) begin
          idx = 3'd0;
        end
        if (idx == 3'd4) begin
          emit         = 1'b1;
          byte_index_d = 3'd0;
          btn_raw      = mpd_pkg::FiveMap[{1'b0, pkt_q[0][2:0] ^ 3'b111}];
          dx           = {pkt_q[1][7], pkt_q[1]} + {pkt_q[3][7], pkt_q[3]};
          dy           = 10'd0 - sum_y;
        end else begin
          store_en     = 1'b1;
          byte_index_d = idx + 3'd1;
        end
      end
      mpd_pkg::ProtoSevenBit: begin
        if (byte_index_q > 3'd2) begin
          idx = 3'd0;
        end
        byte_index_d = idx;
        store_val    = {2'b00, c[5:0]};
        if (idx == 3'd0 && !c[6]) begin
          // Middle-button byte: only valid with bits 4..2 clear.
          if (c[4:2] == 3'b000) begin
            middle_held_d = c[5];
            emit          = 1'b1;
            btn_raw       = {last_buttons_q[2], c[5], last_buttons_q[0]};
          end
        end else if (idx == 3'd2) begin
          emit         = 1'b1;
          byte_index_d = 3'd0;
          btn_raw      = {1'b0, middle_held_q, 1'b0}
                         | mpd_pkg::SevenMap[{1'b0, pkt_q[0][5:4]}];
          dx           = {seven_x[7], seven_x};
          dy           = {{2{seven_y[7]}}, seven_y};
        end else begin
          store_en     = 1'b1;
          byte_index_d = idx + 3'd1;
        end
      end
      mpd_pkg::ProtoPs2: begin
        if (byte_index_q > 3'd2) begin
          idx = 3'd0;
        end
        byte_index_d = idx;
        if (idx == 3'd0 && (c & 8'hC8) != 8'h08) begin
          // Out of sync: drop the byte.
          emit = 1'b0;
        end else if (idx == 3'd2) begin
          emit         = 1'b1;
          byte_index_d = 3'd0;
          btn_raw      = mpd_pkg::Ps2Map[{item_i.shift_held, pkt_q[0][2:0]}];
          dx           = {pkt_q[0][4], pkt_q[1]};
          dy           = 10'd0 - {ps2_y[8], ps2_y};
        end else begin
          store_en     = 1'b1;
          byte_index_d = idx + 3'd1;
        end
      end
      default: begin
        // Unused protocol code: every byte is ignored.
        emit = 1'b0;
      end
    endcase
  end

  // Optional swap of left and right.
  assign btn_final = swap_q ? mpd_pkg::Rev3Map[btn_raw] : btn_raw;

  // Configuration and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol_q     <= mpd_pkg::ProtocolReset;
      swap_q         <= 1'b0;
      byte_index_q   <= 3'd0;
      middle_held_q  <= 1'b0;
      last_buttons_q <= '0;
    end else begin
      if (cfg_i.we && cfg_i.index == mpd_pkg::CfgIdxProtocol) begin
        protocol_q   <= cfg_i.data;
        byte_index_q <= 3'd0;
      end else if (fire) begin
        byte_index_q <= byte_index_d;
      end
      if (cfg_i.we && cfg_i.index == mpd_pkg::CfgIdxSwap) begin
        swap_q <= cfg_i.data[0];
      end
      if (fire) begin
        middle_held_q <= middle_held_d;
      end
      if (fire && emit) begin
        last_buttons_q <= btn_final;
      end
    end
  end

  // Stored packet bytes; the final byte of a packet is used directly.
  always_ff @(posedge clk_i) begin
    if (fire && store_en) begin
      pkt_q[idx[1:0]] <= store_val;
    end
  end

  assign emit_o           = fire && emit;
  assign report_o.buttons = btn_final;
  assign report_o.delta_x = dx;
  assign report_o.delta_y = dy;

endmodule

### src/mpd_out_reg.sv
// Result register that holds one report until the stream sink takes it.
module mpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mpd_pkg::report_t  report_i,
  output logic              out_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output mpd_pkg::report_t  m_report_o
);

  logic             valid_q, valid_d;
  mpd_pkg::report_t report_q;

  // The register can take a new report when empty or being drained.
  assign out_ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      report_q <= report_i;
    end
  end

  assign m_valid_o  = valid_q;
  assign m_report_o = report_q;

endmodule

### src/mouse_packet_decoder.sv
// Top level of the mouse packet decoder: stream ports, configuration port.
//
// Decodes received mouse bytes into reports of buttons and motion in one of three
// formats chosen by the protocol register (0 five-byte serial, 1 seven-bit serial
// with middle-button byte, 2 PS/2, 3 ignores all bytes); the swap register reverses the
// button bits. Writing the protocol register restarts packet assembly. One byte is
// accepted every cycle while the result register is free or being drained; a packet's
// report is decoded from the input register by a single decode stage and loaded into
// the result register. A stalled report holds the decode stage and, once the input
// register is full, the input stream.
module mouse_packet_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [1:0]                    cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Fields from bit 0: rx_byte[7:0], shift_held[8], zero padding[15:9].
  input  logic [mpd_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // Fields from bit 0: buttons[2:0], delta_x[11:3], delta_y[21:12], zero padding[23:22].
  output logic [mpd_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  mpd_pkg::cfg_wr_t cfg;
  mpd_pkg::item_t   s_item, item;
  mpd_pkg::report_t report, m_report;
  logic             item_valid, consume, emit, out_ready;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  assign s_item.rx_byte    = s_axis_tdata_i[7:0];
  assign s_item.shift_held = s_axis_tdata_i[8];

  // Input register.
  mpd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_item_i     (s_item),
    .consume_i    (consume),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Packet assembly and decode.
  mpd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_ready_i  (out_ready),
    .consume_o    (consume),
    .emit_o       (emit),
    .report_o     (report)
  );

  // Result register.
  mpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .report_i    (report),
    .out_ready_o (out_ready),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_report_o  (m_report)
  );

  assign m_axis_tdata_o = {2'b00, m_report.delta_y, m_report.delta_x, m_report.buttons};

endmodule

### src/mpd_checker.sv
// Port-level assertions for the mouse packet decoder, bound to the top level.
module mpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [mpd_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // No report is shown while reset is applied.
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("report valid during reset");

  // With the result register empty, the input side must never stall.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while result register is empty");

  // A stalled report keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled report changed");

  // Vertical motion stays within -256 to 256.
  a_dy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[21:20] == 2'b00 || m_axis_tdata_o[21:20] == 2'b11
                         || m_axis_tdata_o[21:12] == 10'h100))
    else $error("delta_y out of range");

endmodule

bind mouse_packet_decoder mpd_checker u_mpd_checker (.*);
